// ----- rtl/sco_pkg.sv -----
package sco_pkg;

  localparam int NORMAL_FRAC = 14;
  localparam int ROOT_W      = 32;
  localparam int RAD_W       = 2 * ROOT_W;
  localparam int REM_W       = ROOT_W + 3;

  localparam logic [1:0] KIND_PAIR  = 2'd0;
  localparam logic [1:0] KIND_OTHER = 2'd1;
  localparam logic [1:0] KIND_PLANE = 2'd2;

  typedef enum logic [1:0] {
    MODE_ZERO,
    MODE_SPHERE,
    MODE_PLANE
  } mode_t;

  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    mode_t             mode;
    logic [31:0]       value;
  } cell_data_t;

endpackage

// ----- rtl/sphere_contact_overlap.sv -----
// sphere contact overlap: penetration depth of a sphere against a second
// sphere or a plane, one result per input transaction.
// input channel: in_valid/in_stall carry kind, both centres, both radii and
// the plane normal; kind 1 and the unused code give overlap 0.
// output channel: out_valid/out_stall carry overlap (unsigned Q16.16).
// the pipeline runs through registered stages for differences, squares and dot
// terms, sums and range check, then 32 square-root cells (one root bit each),
// then the output register. an item enters every cycle unless in_stall is
// raised; sustained throughput is one transaction per cycle without stalls.
// the whole pipeline moves on a common enable: when out_valid is high and
// out_stall is asserted every stage holds and in_stall is raised, so items
// in flight stay in their stages and nothing is lost.
// reset (rst_n low, synchronous) empties every stage; out_valid is low after.
module sphere_contact_overlap (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_kind,
  input  logic signed [31:0] in_self_x,
  input  logic signed [31:0] in_self_y,
  input  logic signed [31:0] in_self_z,
  input  logic [30:0]        in_self_radius,
  input  logic signed [31:0] in_other_x,
  input  logic signed [31:0] in_other_y,
  input  logic signed [31:0] in_other_z,
  input  logic [30:0]        in_other_radius,
  input  logic signed [15:0] in_normal_x,
  input  logic signed [15:0] in_normal_y,
  input  logic signed [15:0] in_normal_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        out_overlap
);

  logic                en;
  logic                chain_valid [0:sco_pkg::ROOT_W];
  sco_pkg::cell_data_t chain_d     [0:sco_pkg::ROOT_W];
  sco_pkg::cell_data_t last_d;
  logic                out_valid_r;
  logic [31:0]         out_overlap_r;
  logic [31:0]         overlap_nxt;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  sco_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .en              (en),
    .in_valid        (in_valid),
    .in_kind         (in_kind),
    .in_self_x       (in_self_x),
    .in_self_y       (in_self_y),
    .in_self_z       (in_self_z),
    .in_self_radius  (in_self_radius),
    .in_other_x      (in_other_x),
    .in_other_y      (in_other_y),
    .in_other_z      (in_other_z),
    .in_other_radius (in_other_radius),
    .in_normal_x     (in_normal_x),
    .in_normal_y     (in_normal_y),
    .in_normal_z     (in_normal_z),
    .f_valid         (chain_valid[0]),
    .f_d             (chain_d[0])
  );

  for (genvar i = 0; i < sco_pkg::ROOT_W; i++) begin : g_cell
    sco_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .en          (en),
      .c_in_valid  (chain_valid[i]),
      .c_in_d      (chain_d[i]),
      .c_out_valid (chain_valid[i+1]),
      .c_out_d     (chain_d[i+1])
    );
  end

  assign last_d = chain_d[sco_pkg::ROOT_W];

  always_comb begin
    case (last_d.mode)
      sco_pkg::MODE_SPHERE: begin
        overlap_nxt = (last_d.value > last_d.root) ? (last_d.value - last_d.root) : 32'd0;
      end
      sco_pkg::MODE_PLANE: overlap_nxt = last_d.value;
      default:             overlap_nxt = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= chain_valid[sco_pkg::ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_overlap_r <= overlap_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_overlap = out_overlap_r;

endmodule

// ----- rtl/sco_front.sv -----
module sco_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic [1:0]          in_kind,
  input  logic signed [31:0]  in_self_x,
  input  logic signed [31:0]  in_self_y,
  input  logic signed [31:0]  in_self_z,
  input  logic [30:0]         in_self_radius,
  input  logic signed [31:0]  in_other_x,
  input  logic signed [31:0]  in_other_y,
  input  logic signed [31:0]  in_other_z,
  input  logic [30:0]         in_other_radius,
  input  logic signed [15:0]  in_normal_x,
  input  logic signed [15:0]  in_normal_y,
  input  logic signed [15:0]  in_normal_z,
  output logic                f_valid,
  output sco_pkg::cell_data_t f_d
);

  // stage 1: differences and radius sum
  logic                s1_valid_r;
  logic signed [32:0]  s1_dx_r, s1_dy_r, s1_dz_r;
  logic signed [15:0]  s1_nx_r, s1_ny_r, s1_nz_r;
  logic [30:0]         s1_r_r;
  logic [31:0]         s1_rsum_r;
  sco_pkg::mode_t      s1_mode_r;
  sco_pkg::mode_t      s1_mode_nxt;

  // stage 2: squares and dot terms
  logic                s2_valid_r;
  logic [63:0]         s2_sqx_r, s2_sqy_r, s2_sqz_r;
  logic signed [48:0]  s2_px_r, s2_py_r, s2_pz_r;
  logic [30:0]         s2_r_r;
  logic [31:0]         s2_rsum_r;
  sco_pkg::mode_t      s2_mode_r;
  logic [31:0]         ax, ay, az;
  logic signed [32:0]  nx_d, ny_d, nz_d;

  // stage 3: sums
  logic                s3_valid_r;
  logic [65:0]         s3_sq_r;
  logic signed [50:0]  s3_dot_r;
  logic [30:0]         s3_r_r;
  logic [31:0]         s3_rsum_r;
  sco_pkg::mode_t      s3_mode_r;

  // stage 4: range check and plane distance
  logic                s4_valid_r;
  sco_pkg::cell_data_t s4_d_r;
  sco_pkg::cell_data_t s4_d_nxt;
  logic signed [50:0]  dot_neg;
  logic [50:0]         dot_mag;
  logic [36:0]         plane_dist;
  logic [36:0]         r_ext;

  always_comb begin
    unique case (in_kind)
      sco_pkg::KIND_PAIR:  s1_mode_nxt = sco_pkg::MODE_SPHERE;
      sco_pkg::KIND_PLANE: s1_mode_nxt = sco_pkg::MODE_PLANE;
      sco_pkg::KIND_OTHER: s1_mode_nxt = sco_pkg::MODE_ZERO;
      default:             s1_mode_nxt = sco_pkg::MODE_ZERO;
    endcase
  end

  assign nx_d = 33'(s1_dx_r);
  assign ny_d = 33'(s1_dy_r);
  assign nz_d = 33'(s1_dz_r);
  assign ax   = nx_d[32] ? 32'(-nx_d) : nx_d[31:0];
  assign ay   = ny_d[32] ? 32'(-ny_d) : ny_d[31:0];
  assign az   = nz_d[32] ? 32'(-nz_d) : nz_d[31:0];

  assign dot_neg    = -s3_dot_r;
  assign dot_mag    = s3_dot_r[50] ? dot_neg : s3_dot_r;
  assign plane_dist = dot_mag[50:sco_pkg::NORMAL_FRAC];
  assign r_ext      = {6'd0, s3_r_r};

  always_comb begin
    s4_d_nxt       = '0;
    s4_d_nxt.rad   = s3_sq_r[63:0];
    s4_d_nxt.mode  = s3_mode_r;
    s4_d_nxt.value = s3_rsum_r;
    case (s3_mode_r)
      sco_pkg::MODE_SPHERE: begin
        if (s3_sq_r[65:64] != 2'd0) begin
          s4_d_nxt.mode = sco_pkg::MODE_ZERO;
        end
      end
      sco_pkg::MODE_PLANE: begin
        s4_d_nxt.value = (r_ext > plane_dist) ? 32'(r_ext - plane_dist) : 32'd0;
      end
      default: s4_d_nxt.mode = sco_pkg::MODE_ZERO;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_dx_r   <= 33'(in_self_x) - 33'(in_other_x);
      s1_dy_r   <= 33'(in_self_y) - 33'(in_other_y);
      s1_dz_r   <= 33'(in_self_z) - 33'(in_other_z);
      s1_nx_r   <= in_normal_x;
      s1_ny_r   <= in_normal_y;
      s1_nz_r   <= in_normal_z;
      s1_r_r    <= in_self_radius;
      s1_rsum_r <= {1'b0, in_self_radius} + {1'b0, in_other_radius};
      s1_mode_r <= s1_mode_nxt;

      s2_sqx_r  <= {32'd0, ax} * {32'd0, ax};
      s2_sqy_r  <= {32'd0, ay} * {32'd0, ay};
      s2_sqz_r  <= {32'd0, az} * {32'd0, az};
      s2_px_r   <= 49'(s1_dx_r) * 49'(s1_nx_r);
      s2_py_r   <= 49'(s1_dy_r) * 49'(s1_ny_r);
      s2_pz_r   <= 49'(s1_dz_r) * 49'(s1_nz_r);
      s2_r_r    <= s1_r_r;
      s2_rsum_r <= s1_rsum_r;
      s2_mode_r <= s1_mode_r;

      s3_sq_r   <= {2'd0, s2_sqx_r} + {2'd0, s2_sqy_r} + {2'd0, s2_sqz_r};
      s3_dot_r  <= 51'(s2_px_r) + 51'(s2_py_r) + 51'(s2_pz_r);
      s3_r_r    <= s2_r_r;
      s3_rsum_r <= s2_rsum_r;
      s3_mode_r <= s2_mode_r;

      s4_d_r    <= s4_d_nxt;
    end
  end

  assign f_valid = s4_valid_r;
  assign f_d     = s4_d_r;

endmodule

// ----- rtl/sco_cell.sv -----
module sco_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                c_in_valid,
  input  sco_pkg::cell_data_t c_in_d,
  output logic                c_out_valid,
  output sco_pkg::cell_data_t c_out_d
);

  logic                      valid_r;
  sco_pkg::cell_data_t       d_r;
  sco_pkg::cell_data_t       d_nxt;
  logic [sco_pkg::REM_W-1:0] rem_sh;
  logic [sco_pkg::REM_W-1:0] trial;
  logic                      ge;

  // one root bit per cell, two radicand bits brought down
  assign rem_sh = {c_in_d.rem[sco_pkg::REM_W-3:0],
                   c_in_d.rad[sco_pkg::RAD_W-1:sco_pkg::RAD_W-2]};
  assign trial  = {1'b0, c_in_d.root, 2'b01};
  assign ge     = (rem_sh >= trial);

  always_comb begin
    d_nxt      = c_in_d;
    d_nxt.rad  = {c_in_d.rad[sco_pkg::RAD_W-3:0], 2'b00};
    d_nxt.rem  = ge ? (rem_sh - trial) : rem_sh;
    d_nxt.root = {c_in_d.root[sco_pkg::ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= c_in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign c_out_valid = valid_r;
  assign c_out_d     = d_r;

endmodule

// ----- rtl/sco_checker.sv -----
module sco_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_overlap
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_overlap))
    else $error("stalled result changed");

  // input is only held off by a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  // input never held off while the result side is free
  a_no_stall_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

endmodule

bind sphere_contact_overlap sco_checker u_sco_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_overlap (out_overlap)
);

// ----- test/sphere_contact_overlap_tb.sv -----
module sphere_contact_overlap_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 60;
  localparam int RANDOM_ITEMS = 400;
  localparam logic signed [31:0] C_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] C_MAX = 32'sh7FFF_FFFF;
  localparam logic [30:0] R_MAX = 31'h7FFF_FFFF;
  localparam logic signed [15:0] N_ONE = 16'sd16384;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] self_x;
    logic signed [31:0] self_y;
    logic signed [31:0] self_z;
    logic [30:0]        self_radius;
    logic signed [31:0] other_x;
    logic signed [31:0] other_y;
    logic signed [31:0] other_z;
    logic [30:0]        other_radius;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
  } contact_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  logic     out_valid;
  logic     out_stall = 1'b0;
  logic [31:0] out_overlap;
  contact_t in_item = '0;
  logic     in_taken = 1'b0;

  contact_t    pair_q[$];
  logic [31:0] overlap_q[$];

  int cycle_count = 0;
  int mismatch_count = 0;
  int checked_count = 0;
  int touching_count = 0;
  int kind_count[4] = '{0, 0, 0, 0};
  int burst_left = 0;
  int gap_left = 0;
  int stall_run = 0;
  logic stall_hold = 1'b0;

  sphere_contact_overlap u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_item.kind),
    .in_self_x       (in_item.self_x),
    .in_self_y       (in_item.self_y),
    .in_self_z       (in_item.self_z),
    .in_self_radius  (in_item.self_radius),
    .in_other_x      (in_item.other_x),
    .in_other_y      (in_item.other_y),
    .in_other_z      (in_item.other_z),
    .in_other_radius (in_item.other_radius),
    .in_normal_x     (in_item.normal_x),
    .in_normal_y     (in_item.normal_y),
    .in_normal_z     (in_item.normal_z),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_overlap     (out_overlap)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [31:0] contact_overlap(contact_t c);
    longint d[3];
    longint nrm[3];
    longint unsigned mag_d, root, trial, depth;
    logic [65:0] dist_sq;
    longint dot;
    logic [31:0] reach;
    d[0] = longint'($signed(c.self_x)) - longint'($signed(c.other_x));
    d[1] = longint'($signed(c.self_y)) - longint'($signed(c.other_y));
    d[2] = longint'($signed(c.self_z)) - longint'($signed(c.other_z));
    nrm[0] = longint'($signed(c.normal_x));
    nrm[1] = longint'($signed(c.normal_y));
    nrm[2] = longint'($signed(c.normal_z));
    if (c.kind == sco_pkg::KIND_PAIR) begin
      dist_sq = '0;
      for (int i = 0; i < 3; i++) begin
        mag_d = (d[i] < 0) ? -d[i] : d[i];
        dist_sq = dist_sq + 66'(mag_d * mag_d);
      end
      // squared distance beyond 64 bits is further than any radius sum
      if (dist_sq[65:64] != 2'b00) return 32'd0;
      root = 0;
      for (int b = 31; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= dist_sq[63:0]) root = trial;
      end
      reach = {1'b0, c.self_radius} + {1'b0, c.other_radius};
      return (reach > root) ? reach - root[31:0] : 32'd0;
    end else if (c.kind == sco_pkg::KIND_PLANE) begin
      dot = 0;
      for (int i = 0; i < 3; i++) dot = dot + d[i] * nrm[i];
      depth = ((dot < 0) ? -dot : dot) >> sco_pkg::NORMAL_FRAC;
      return (depth < c.self_radius) ? {1'b0, c.self_radius} - depth[31:0] : 32'd0;
    end
    return 32'd0;
  endfunction

  function automatic contact_t make_contact(
    logic [1:0] k,
    logic signed [31:0] sx, logic signed [31:0] sy, logic signed [31:0] sz,
    logic [30:0] sr,
    logic signed [31:0] ox, logic signed [31:0] oy, logic signed [31:0] oz,
    logic [30:0] orad,
    logic signed [15:0] nx, logic signed [15:0] ny, logic signed [15:0] nz
  );
    contact_t c;
    c.kind = k;
    c.self_x = sx;
    c.self_y = sy;
    c.self_z = sz;
    c.self_radius = sr;
    c.other_x = ox;
    c.other_y = oy;
    c.other_z = oz;
    c.other_radius = orad;
    c.normal_x = nx;
    c.normal_y = ny;
    c.normal_z = nz;
    return c;
  endfunction

  // signed offset at most 2^(bits-1) in magnitude
  function automatic logic signed [31:0] jitter(int unsigned bits);
    return $signed($urandom) >>> (32 - bits);
  endfunction

  function automatic contact_t random_contact();
    contact_t c;
    int unsigned shape, span;
    shape = $urandom_range(0, 9);
    span = $urandom_range(1, 31);
    c.kind = 2'($urandom);
    c.self_x = $urandom;
    c.self_y = $urandom;
    c.self_z = $urandom;
    c.self_radius = 31'($urandom);
    c.other_x = $urandom;
    c.other_y = $urandom;
    c.other_z = $urandom;
    c.other_radius = 31'($urandom);
    c.normal_x = 16'($urandom);
    c.normal_y = 16'($urandom);
    c.normal_z = 16'($urandom);
    if (shape < 7) begin
      // nearby bodies so that a good share of transactions actually touch
      c.other_x = c.self_x + jitter(span);
      c.other_y = c.self_y + jitter(span);
      c.other_z = c.self_z + jitter(span);
      c.self_radius = 31'($urandom >> (32 - span));
      c.other_radius = 31'($urandom >> (32 - span));
    end
    if (shape < 4) begin
      c.kind = sco_pkg::KIND_PAIR;
    end else if (shape < 7) begin
      c.kind = sco_pkg::KIND_PLANE;
      if ($urandom_range(0, 3) != 0) begin
        c.normal_x = 16'($signed($urandom) >>> 17);
        c.normal_y = 16'($signed($urandom) >>> 17);
        c.normal_z = 16'($signed($urandom) >>> 17);
        case ($urandom_range(0, 5))
          0: c.normal_x = N_ONE;
          1: c.normal_y = -N_ONE;
          2: c.normal_z = N_ONE;
          default: ;
        endcase
      end
    end else if (shape == 7) begin
      c.kind = $urandom_range(0, 1) ? sco_pkg::KIND_OTHER : KIND_SPARE;
    end
    return c;
  endfunction

  task automatic note_failure(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", msg);
  endtask

  // driver: bursts of transactions with random gaps, receiver stall pattern
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (gap_left > 0 || pair_q.size() == 0) begin
        in_valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        in_item <= pair_q.pop_front();
        in_valid <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
    if (stall_run <= 0) begin
      stall_hold = ~stall_hold;
      stall_run = $urandom_range(1, 12);
    end
    stall_run--;
    case ((cycle_count / 250) % 4)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      2: out_stall <= stall_hold;
      default: out_stall <= (cycle_count % 3 == 0);
    endcase
  end

  // monitor: record accepted inputs, check accepted results
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      overlap_q.push_back(contact_overlap(in_item));
      kind_count[in_item.kind]++;
    end
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (overlap_q.size() == 0) begin
        note_failure($sformatf("unexpected result transaction: overlap %h", out_overlap));
      end else begin
        checked_count++;
        if (overlap_q[0] != 0) touching_count++;
        if (out_overlap !== overlap_q[0])
          note_failure($sformatf("result %0d overlap: expected %h, got %h",
                                 checked_count, overlap_q[0], out_overlap));
        void'(overlap_q.pop_front());
      end
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycle_count);
    $display("sphere_contact_overlap: mismatch");
    $finish;
  end

  initial begin
    // coincident centres, largest radii
    pair_q.push_back(make_contact(sco_pkg::KIND_PAIR, 0, 0, 0, R_MAX, 0, 0, 0, R_MAX,
                                  0, 0, 0));
    // squared distance overflows 64 bits
    pair_q.push_back(make_contact(sco_pkg::KIND_PAIR, C_MIN, C_MIN, C_MIN, R_MAX,
                                  C_MAX, C_MAX, C_MAX, R_MAX, 0, 0, 0));
    // one far axis, distance just above the largest radius sum
    pair_q.push_back(make_contact(sco_pkg::KIND_PAIR, C_MIN, 0, 0, R_MAX, C_MAX, 0, 0, R_MAX,
                                  0, 0, 0));
    pair_q.push_back(make_contact(sco_pkg::KIND_PAIR, C_MIN, C_MIN, 0, R_MAX, 0, 0, 0, R_MAX,
                                  0, 0, 0));
    pair_q.push_back(make_contact(sco_pkg::KIND_PAIR, C_MAX, C_MAX, C_MAX, 0,
                                  C_MIN, C_MIN, C_MIN, 0, -1, -1, -1));
    // exact touching and one unit of overlap
    pair_q.push_back(make_contact(sco_pkg::KIND_PAIR, 0, 0, 0, 31'h2_0000,
                                  32'h3_0000, 32'h4_0000, 0, 31'h3_0000, 0, 0, 0));
    pair_q.push_back(make_contact(sco_pkg::KIND_PAIR, 0, 0, 0, 31'h2_0000,
                                  32'h3_0000, 32'h4_0000, 0, 31'h3_0001, 0, 0, 0));
    pair_q.push_back(make_contact(sco_pkg::KIND_PAIR, -1, -1, -1, 0, -1, -1, -1, 0,
                                  -1, -1, -1));
    pair_q.push_back(make_contact(sco_pkg::KIND_PAIR, 5, -7, 3, 31'd10, -2, 1, 0, 31'd1,
                                  0, 0, 0));
    // non-sphere and the spare kind code
    pair_q.push_back(make_contact(sco_pkg::KIND_OTHER, 0, 0, 0, R_MAX, 0, 0, 0, R_MAX,
                                  N_ONE, 0, 0));
    pair_q.push_back(make_contact(KIND_SPARE, 0, 0, 0, R_MAX, 0, 0, 0, R_MAX, 0, 0, N_ONE));
    // plane contact on both sides of the plane
    pair_q.push_back(make_contact(sco_pkg::KIND_PLANE, 0, 0, 32'h5_0000, 31'h8_0000,
                                  0, 0, 0, 0, 0, 0, N_ONE));
    pair_q.push_back(make_contact(sco_pkg::KIND_PLANE, 0, 0, -32'sh5_0000, 31'h8_0000,
                                  0, 0, 0, R_MAX, 0, 0, N_ONE));
    pair_q.push_back(make_contact(sco_pkg::KIND_PLANE, C_MAX, C_MIN, C_MAX, R_MAX,
                                  C_MIN, C_MAX, C_MIN, 0, 0, 0, 0));
    // most negative normal at the coordinate extremes
    pair_q.push_back(make_contact(sco_pkg::KIND_PLANE, C_MIN, C_MIN, C_MIN, R_MAX,
                                  C_MAX, C_MAX, C_MAX, R_MAX, 16'sh8000, 16'sh8000, 16'sh8000));
    pair_q.push_back(make_contact(sco_pkg::KIND_PLANE, C_MAX, C_MAX, C_MAX, R_MAX,
                                  C_MIN, C_MIN, C_MIN, 0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
    // small negative dot product truncates to zero distance
    pair_q.push_back(make_contact(sco_pkg::KIND_PLANE, -1, 0, 0, 31'd1, 0, 0, 0, 0,
                                  16'sd16383, 0, 0));
    pair_q.push_back(make_contact(sco_pkg::KIND_PLANE, 32'h1_0000, 0, 0, 31'd0, 0, 0, 0, 0,
                                  N_ONE, 0, 0));
    pair_q.push_back(make_contact(sco_pkg::KIND_PLANE, 32'h2_0000, 32'h2_0000, 0, 31'h4_0000,
                                  0, 0, 0, 0, -N_ONE, 16'sd11585, -16'sd11585));
    for (int n = 0; n < RANDOM_ITEMS; n++) pair_q.push_back(random_contact());

    repeat (10) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    while (pair_q.size() != 0 || in_valid || overlap_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d results checked, %0d with nonzero overlap, in %0d cycles",
             checked_count, touching_count, cycle_count);
    $display("sphere pairs %0d, non-sphere %0d, planes %0d, spare kind %0d, failures %0d",
             kind_count[sco_pkg::KIND_PAIR], kind_count[sco_pkg::KIND_OTHER],
             kind_count[sco_pkg::KIND_PLANE], kind_count[KIND_SPARE], mismatch_count);
    if (mismatch_count == 0 && overlap_q.size() == 0) begin
      $display("sphere_contact_overlap: match");
    end else begin
      $display("sphere_contact_overlap: mismatch");
    end
    $finish;
  end

endmodule
